@@ rtl/qoi_image_decoder_top_defines.svh @@
// Assertion macros for the decoder's checker file.
`ifndef QOI_IMAGE_DECODER_TOP_DEFINES_SVH
`define QOI_IMAGE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QOI_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qoi decoder check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define QOI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qoi decoder check failed");

`endif

@@ rtl/qoi_pkg.sv @@
// Types, constants and helper functions for the QOI chunk decoder.
package qoi_pkg;

  localparam int PIXEL_W            = 32;
  localparam int BYTE_W             = 8;
  localparam int CFG_W              = 32;
  localparam int INDEX_DEPTH        = 64;
  localparam int INDEX_AW           = $clog2(INDEX_DEPTH);
  localparam int RUN_W              = INDEX_AW + 1;
  localparam int DEFAULT_COUNT_BITS = 32;
  localparam logic [CFG_W-1:0] PIXEL_TOTAL_RESET = 32'd1;

  // Whole-byte op codes
  localparam logic [BYTE_W-1:0] OP_RGB  = 8'hFE;
  localparam logic [BYTE_W-1:0] OP_RGBA = 8'hFF;

  // Two-bit tag codes in the top bits of a tag byte
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  // Red sits in the low byte so the struct maps straight onto tdata
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam pixel_t PREV_RESET = '{alpha: 8'hFF, blue: 8'h00, green: 8'h00, red: 8'h00};

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_RGB  = 2'd1,
    PH_RGBA = 2'd2,
    PH_LUMA = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  // (3r + 5g + 7b + 11a) mod 64; only the low six bits of each term matter
  function automatic logic [INDEX_AW-1:0] color_hash(input pixel_t p);
    return INDEX_AW'(p.red[INDEX_AW-1:0]   * INDEX_AW'(3) +
                     p.green[INDEX_AW-1:0] * INDEX_AW'(5) +
                     p.blue[INDEX_AW-1:0]  * INDEX_AW'(7) +
                     p.alpha[INDEX_AW-1:0] * INDEX_AW'(11));
  endfunction

endpackage

@@ rtl/qoi_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module qoi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/qoi_image_decoder_top.sv @@
// QOI chunk stream decoder: encoded bytes in, RGBA pixels out.
//
// Feed the chunk bytes that follow the 14-byte header, one per transaction, with
// s_axis_tuser[0] high on the first byte of each image; write the image's pixel
// count to cfg_data first. A byte is taken in the idle cycle, decoded in the next
// cycle once the color table read returns; the n pixels that a byte yields (n is
// 0, 1, or up to 62 for a run) are emitted before the next byte is taken. The
// pixel loop runs through a single output register, one pixel per cycle while the
// output is not stalled. The 64-entry color table lives in a RAM with a registered
// read; per-entry valid flags make it read as zero after reset or start of image,
// so no clearing pass is needed. After the last pixel (marked in m_axis_tuser[0])
// further bytes are swallowed until the next start of image, which also drops the
// trailing end marker.
module qoi_image_decoder_top #(
  parameter int PIXEL_COUNT_BITS = qoi_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration: pixel_total
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [qoi_pkg::CFG_W-1:0]    cfg_data,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [qoi_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]                   s_axis_tuser,  // [0] start_of_image
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [qoi_pkg::PIXEL_W-1:0]  m_axis_tdata,  // [7:0] red, [15:8] green,
                                                      // [23:16] blue, [31:24] alpha
  output logic                         m_axis_tlast,  // last_of_run
  output logic [0:0]                   m_axis_tuser   // [0] image_done
);

  import qoi_pkg::*;

  state_t                      state;
  phase_t                      phase, phase_next;
  logic [BYTE_W-1:0]           byte_q;
  logic [1:0]                  pend_cnt, pend_cnt_next;
  logic [23:0]                 pend_data, pend_data_next;
  pixel_t                      prev;
  logic [PIXEL_COUNT_BITS-1:0] pix_count, count_inc, total_masked;
  logic                        finished;
  logic [CFG_W-1:0]            pixel_total;
  logic [INDEX_DEPTH-1:0]      entry_valid;
  pixel_t                      run_pix;
  logic [RUN_W-1:0]            run_left;
  logic                        out_valid, out_last, out_done;
  pixel_t                      out_pix;

  logic                        accept;
  logic [PIXEL_W-1:0]          ram_rdata;
  pixel_t                      table_px, emit_px;
  logic [RUN_W-1:0]            emit_n;
  logic [5:0]                  vg;
  logic [3:0]                  dr, db;
  logic                        ram_we;
  logic                        is_done, is_last;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_pix;
  assign m_axis_tlast    = out_last;
  assign m_axis_tuser[0] = out_done;

  // Color table: read addressed by the incoming byte, result used in decode
  qoi_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(INDEX_DEPTH)
  ) u_index_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(color_hash(emit_px)),
    .wdata(emit_px),
    .raddr(s_axis_tdata[INDEX_AW-1:0]),
    .rdata(ram_rdata)
  );

  assign table_px = entry_valid[byte_q[INDEX_AW-1:0]] ? pixel_t'(ram_rdata) : '0;

  // Op decode on the latched byte
  assign vg = pend_data[5:0];
  assign dr = byte_q[7:4];
  assign db = byte_q[3:0];

  always_comb begin
    emit_px        = prev;
    emit_n         = '0;
    phase_next     = phase;
    pend_cnt_next  = pend_cnt;
    pend_data_next = pend_data;
    case (phase)
      PH_RGB, PH_RGBA: begin
        if (phase == PH_RGB && pend_cnt == 2'd2) begin
          emit_px.red    = pend_data[15:8];
          emit_px.green  = pend_data[7:0];
          emit_px.blue   = byte_q;
          emit_n         = RUN_W'(1);
          phase_next     = PH_TAG;
          pend_cnt_next  = '0;
          pend_data_next = '0;
        end else if (phase == PH_RGBA && pend_cnt == 2'd3) begin
          emit_px.red    = pend_data[23:16];
          emit_px.green  = pend_data[15:8];
          emit_px.blue   = pend_data[7:0];
          emit_px.alpha  = byte_q;
          emit_n         = RUN_W'(1);
          phase_next     = PH_TAG;
          pend_cnt_next  = '0;
          pend_data_next = '0;
        end else begin
          pend_cnt_next  = pend_cnt + 2'd1;
          pend_data_next = {pend_data[15:0], byte_q};
        end
      end
      PH_LUMA: begin
        // green delta biased by 32, red/blue deltas relative to green biased by 8
        emit_px.red    = prev.red + {2'b00, vg} + 8'd224 + {4'b0000, dr} + 8'd248;
        emit_px.green  = prev.green + {2'b00, vg} + 8'd224;
        emit_px.blue   = prev.blue + {2'b00, vg} + 8'd224 + {4'b0000, db} + 8'd248;
        emit_n         = RUN_W'(1);
        phase_next     = PH_TAG;
        pend_cnt_next  = '0;
        pend_data_next = '0;
      end
      default: begin
        if (byte_q == OP_RGB) begin
          phase_next     = PH_RGB;
          pend_cnt_next  = '0;
          pend_data_next = '0;
        end else if (byte_q == OP_RGBA) begin
          phase_next     = PH_RGBA;
          pend_cnt_next  = '0;
          pend_data_next = '0;
        end else begin
          case (byte_q[7:6])
            TAG_INDEX: begin
              emit_px = table_px;
              emit_n  = RUN_W'(1);
            end
            TAG_DIFF: begin
              emit_px.red   = prev.red + {6'd0, byte_q[5:4]} + 8'd254;
              emit_px.green = prev.green + {6'd0, byte_q[3:2]} + 8'd254;
              emit_px.blue  = prev.blue + {6'd0, byte_q[1:0]} + 8'd254;
              emit_n        = RUN_W'(1);
            end
            TAG_LUMA: begin
              phase_next     = PH_LUMA;
              pend_cnt_next  = '0;
              pend_data_next = {18'd0, byte_q[5:0]};
            end
            default: begin
              emit_n = {1'b0, byte_q[5:0]} + RUN_W'(1);
            end
          endcase
        end
      end
    endcase
  end

  assign ram_we = (state == ST_DECODE) && !finished && (emit_n != '0);

  // Pixel count and end of image
  assign total_masked = pixel_total[PIXEL_COUNT_BITS-1:0];
  assign count_inc    = pix_count + PIXEL_COUNT_BITS'(1);
  assign is_done      = (count_inc == total_masked);
  assign is_last      = (run_left == RUN_W'(1)) || is_done;

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_TAG;
      pend_cnt    <= '0;
      pend_data   <= '0;
      prev        <= PREV_RESET;
      pix_count   <= '0;
      finished    <= 1'b0;
      entry_valid <= '0;
      pixel_total <= PIXEL_TOTAL_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pixel_total <= cfg_data;
      end
      // output register empties when taken, unless the run loop reloads it
      if (out_valid && m_axis_tready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            byte_q <= s_axis_tdata;
            if (s_axis_tuser[0]) begin
              phase       <= PH_TAG;
              pend_cnt    <= '0;
              pend_data   <= '0;
              prev        <= PREV_RESET;
              pix_count   <= '0;
              finished    <= 1'b0;
              entry_valid <= '0;
            end
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (finished) begin
            state <= ST_IDLE;
          end else begin
            phase     <= phase_next;
            pend_cnt  <= pend_cnt_next;
            pend_data <= pend_data_next;
            if (emit_n != '0) begin
              prev                            <= emit_px;
              entry_valid[color_hash(emit_px)] <= 1'b1;
              run_pix                         <= emit_px;
              run_left                        <= emit_n;
              state                           <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          // one pixel per cycle whenever the output slot is free
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_pix   <= run_pix;
            out_last  <= is_last;
            out_done  <= is_done;
            pix_count <= count_inc;
            run_left  <= run_left - RUN_W'(1);
            if (is_done) begin
              finished <= 1'b1;
            end
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/qoi_checker.sv @@
// Port-level checks for the QOI decoder, bound to the top level.
`include "qoi_image_decoder_top_defines.svh"

module qoi_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [qoi_pkg::PIXEL_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast,
  input logic [0:0]                  m_axis_tuser
);

  // A stalled pixel stays offered and unchanged
  `QOI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // The final pixel of an image always closes its run
  `QOI_ASSERT_NOW(a_done_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

  // No new byte is taken while a run still has pixels to come
  `QOI_ASSERT_NOW(a_run_blocks_input, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind qoi_image_decoder_top qoi_checker u_qoi_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
